>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared definitions of the round-robin tick scheduler
// Field widths, command and register codes, the queue entry record and the
// control record that drives the row of queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W       = 8;
   localparam int TIME_W     = 16;
   localparam int BURST_W    = 12;
   localparam int QUANT_W    = 8;
   localparam int SUM_W      = 32;
   localparam int CNT_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // request commands
   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // register map
   localparam logic [CSR_ADDR_W-1:0] CSR_QUANTUM_ADDR = 2'd0;
   localparam logic [QUANT_W-1:0]    QUANTUM_RESET    = 8'd1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] served;
   } entry_type;

   // shift: every cell takes its right neighbor's entry
   // load:  the cell at the target index takes the broadcast entry instead
   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/rrts_req_if.sv
// ----------------------------------------------------------------------------
// rrts_req_if: request channel of the round-robin tick scheduler
// Valid/ready channel carrying one arrival or tick request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrts_req_if import rrts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [ID_W-1:0]    proc_id;
   logic [BURST_W-1:0] burst;

   modport source (output valid, cmd, proc_id, burst, input ready);
   modport sink   (input valid, cmd, proc_id, burst, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rrts_rsp_if.sv
// ----------------------------------------------------------------------------
// rrts_rsp_if: response channel of the round-robin tick scheduler
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrts_rsp_if import rrts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               busy_res;
   logic [ID_W-1:0]    run_id;
   logic [BURST_W-1:0] run_elapsed;
   logic               done_res;
   logic [TIME_W-1:0]  turnaround;
   logic [TIME_W-1:0]  waiting;
   logic [SUM_W-1:0]   total_turnaround;
   logic [SUM_W-1:0]   total_waiting;
   logic [CNT_W-1:0]   done_count;
   logic [TIME_W-1:0]  time_now;

   modport source (
      output valid, accepted, busy_res, run_id, run_elapsed, done_res, turnaround,
             waiting, total_turnaround, total_waiting, done_count, time_now,
      input  ready
   );
   modport sink (
      input  valid, accepted, busy_res, run_id, run_elapsed, done_res, turnaround,
             waiting, total_turnaround, total_waiting, done_count, time_now,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/rrts_cell.sv
// ----------------------------------------------------------------------------
// rrts_cell: one slot of the ready queue
// Holds one entry; each cycle it holds, takes its right neighbor's entry, or
// loads the broadcast entry when the target index is its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_cell import rrts_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  wire logic             clock,
   input  wire chain_ctl_type    ctl,
   input  wire logic [IDX_W-1:0] tgt_idx,
   input  wire entry_type        load_entry,
   input  wire entry_type        nbr_entry,
   output      entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;

   assign hit = (tgt_idx == IDX_W'(IDX));

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load && hit) begin
         entry_in = load_entry;
      end else if (ctl.shift) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/core/rrts_chain.sv
// ----------------------------------------------------------------------------
// rrts_chain: the ready queue as a row of cells
// Cell 0 is the queue head; a shift moves every entry one place toward it.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_chain import rrts_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  wire logic             clock,
   input  wire chain_ctl_type    ctl,
   input  wire logic [IDX_W-1:0] tgt_idx,
   input  wire entry_type        load_entry,
   output      entry_type        head_entry
);

   entry_type cell_entry [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type nbr;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign nbr = cell_entry[i];
      end else begin : g_mid
         assign nbr = cell_entry[i+1];
      end

      rrts_cell #(
         .IDX_W (IDX_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .tgt_idx    (tgt_idx),
         .load_entry (load_entry),
         .nbr_entry  (nbr),
         .entry      (cell_entry[i])
      );
   end

   assign head_entry = cell_entry[0];

endmodule

`default_nettype wire

>>> rtl/core/round_robin_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler_top: round-robin scheduler with a bounded queue
// Arrival requests enqueue processes; tick requests run the head process for
// one unit and report completions with running totals.
// ----------------------------------------------------------------------------
// Each request passes through the idle and execute states: in idle the head
// cell of the queue is sampled and the served count, completion test, quantum
// test and turnaround are computed; in execute the chain of queue cells is
// updated (shift, rotate to tail, or append), the totals are accumulated and
// the response register is loaded. A new request is taken only once the
// previous one finishes; a response that is not taken holds the block in its
// execute state. The queue is a row of QUEUE_DEPTH cells, head at cell 0; no
// clearing pass is needed after reset. Arrivals to a full queue are answered
// with accepted low. The quantum register lies at byte address 0 and should
// be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_tick_scheduler_top import rrts_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rrts_req_if.sink                   req_chan,
   rrts_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [QUANT_W-1:0] quantum_ff, quantum_in;

   assign pready = 1'b1;

   always_comb begin
      quantum_in = quantum_ff;
      if (psel && penable && pwrite && (paddr == CSR_QUANTUM_ADDR)) begin
         quantum_in = pwdata[QUANT_W-1:0];
      end
   end

   assign prdata = (paddr == CSR_QUANTUM_ADDR) ? CSR_DATA_W'(quantum_ff) : '0;

   // ------------------------------------------------------------------
   // scheduler state
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [QUANT_W-1:0] slice_ff, slice_in;
   logic [SUM_W-1:0]   sum_ta_ff, sum_ta_in;
   logic [SUM_W-1:0]   sum_wt_ff, sum_wt_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // capture when a request is taken
   logic               cmd_ff, cmd_in;
   logic [ID_W-1:0]    pid_ff, pid_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic               busy_ff, busy_in;
   logic               full_ff, full_in;
   logic               done_ff, done_in;
   logic               rot_ff, rot_in;
   logic [TIME_W-1:0]  ta_ff, ta_in;
   entry_type          run_ff, run_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic               rsp_busy_ff, rsp_busy_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [BURST_W-1:0] rsp_elapsed_ff, rsp_elapsed_in;
   logic               rsp_done_ff, rsp_done_in;
   logic [TIME_W-1:0]  rsp_ta_ff, rsp_ta_in;
   logic [TIME_W-1:0]  rsp_wt_ff, rsp_wt_in;
   logic [SUM_W-1:0]   rsp_sum_ta_ff, rsp_sum_ta_in;
   logic [SUM_W-1:0]   rsp_sum_wt_ff, rsp_sum_wt_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;

   // queue chain
   chain_ctl_type      chain_ctl;
   logic [IDX_W-1:0]   chain_tgt;
   entry_type          chain_load;
   entry_type          head_entry;

   logic               req_fire;
   logic               exec_fire;
   logic [QUANT_W:0]   slice_nx;
   logic [BURST_W-1:0] served_nx;
   logic [TIME_W-1:0]  wt;
   logic [SUM_W:0]     sum_ta_add;
   logic [SUM_W:0]     sum_wt_add;

   rrts_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .tgt_idx    (chain_tgt),
      .load_entry (chain_load),
      .head_entry (head_entry)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign exec_fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   // head-cell evaluation for the request being taken
   assign served_nx = head_entry.served + BURST_W'(1);
   assign slice_nx  = {1'b0, slice_ff} + (QUANT_W+1)'(1);

   // waiting time, clamped at zero after time wraparound
   assign wt = (ta_ff >= TIME_W'(run_ff.burst)) ? (ta_ff - TIME_W'(run_ff.burst)) : '0;

   assign sum_ta_add = {1'b0, sum_ta_ff} + (SUM_W+1)'(ta_ff);
   assign sum_wt_add = {1'b0, sum_wt_ff} + (SUM_W+1)'(wt);

   // ------------------------------------------------------------------
   // capture stage
   // ------------------------------------------------------------------
   always_comb begin
      cmd_in   = cmd_ff;
      pid_in   = pid_ff;
      burst_in = burst_ff;
      busy_in  = busy_ff;
      full_in  = full_ff;
      done_in  = done_ff;
      rot_in   = rot_ff;
      ta_in    = ta_ff;
      run_in   = run_ff;
      if (req_fire) begin
         cmd_in        = req_chan.cmd;
         pid_in        = req_chan.proc_id;
         burst_in      = req_chan.burst;
         busy_in       = (occ_ff != '0);
         full_in       = (occ_ff == OCC_W'(QUEUE_DEPTH));
         done_in       = (served_nx >= head_entry.burst);
         rot_in        = (slice_nx >= {1'b0, quantum_ff});
         ta_in         = time_ff + TIME_W'(1) - head_entry.arrival;
         run_in        = head_entry;
         run_in.served = served_nx;
      end
   end

   // ------------------------------------------------------------------
   // control: state machine, queue update, totals, response
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      time_in        = time_ff;
      slice_in       = slice_ff;
      sum_ta_in      = sum_ta_ff;
      sum_wt_in      = sum_wt_ff;
      count_in       = count_ff;
      chain_ctl      = '0;
      chain_tgt      = '0;
      chain_load     = run_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in     = rsp_acc_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_ta_in      = rsp_ta_ff;
      rsp_wt_in      = rsp_wt_ff;
      rsp_sum_ta_in  = rsp_sum_ta_ff;
      rsp_sum_wt_in  = rsp_sum_wt_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_time_in    = rsp_time_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_acc_in     = 1'b0;
               rsp_busy_in    = 1'b0;
               rsp_id_in      = '0;
               rsp_elapsed_in = '0;
               rsp_done_in    = 1'b0;
               rsp_ta_in      = '0;
               rsp_wt_in      = '0;
               rsp_time_in    = time_ff;

               if (cmd_ff == CMD_ARRIVAL) begin
                  // append at the tail unless the queue is full
                  if (!full_ff) begin
                     chain_ctl.load    = 1'b1;
                     chain_tgt         = occ_ff[IDX_W-1:0];
                     chain_load.id      = pid_ff;
                     chain_load.arrival = time_ff;
                     chain_load.burst   = burst_ff;
                     chain_load.served  = '0;
                     occ_in            = occ_ff + OCC_W'(1);
                     rsp_acc_in        = 1'b1;
                  end
               end else begin
                  time_in = time_ff + TIME_W'(1);
                  if (busy_ff) begin
                     rsp_busy_in    = 1'b1;
                     rsp_id_in      = run_ff.id;
                     rsp_elapsed_in = run_ff.served;
                     if (done_ff) begin
                        // retire the head: drop it and advance the row
                        chain_ctl.shift = 1'b1;
                        occ_in          = occ_ff - OCC_W'(1);
                        slice_in        = '0;
                        rsp_done_in     = 1'b1;
                        rsp_ta_in       = ta_ff;
                        rsp_wt_in       = wt;
                        sum_ta_in       = sum_ta_add[SUM_W] ? '1 : sum_ta_add[SUM_W-1:0];
                        sum_wt_in       = sum_wt_add[SUM_W] ? '1 : sum_wt_add[SUM_W-1:0];
                        if (count_ff != '1) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end else if (rot_ff) begin
                        // quantum spent: advance the row, head goes to the tail
                        chain_ctl.shift = 1'b1;
                        chain_ctl.load  = 1'b1;
                        chain_tgt       = IDX_W'(occ_ff - OCC_W'(1));
                        slice_in        = '0;
                     end else begin
                        // keep running: write back the served count in place
                        chain_ctl.load = 1'b1;
                        chain_tgt      = '0;
                        slice_in       = slice_nx[QUANT_W-1:0];
                     end
                  end else begin
                     slice_in = '0;
                  end
               end

               rsp_sum_ta_in = sum_ta_in;
               rsp_sum_wt_in = sum_wt_in;
               rsp_count_in  = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quantum_ff   <= QUANTUM_RESET;
         occ_ff       <= '0;
         time_ff      <= '0;
         slice_ff     <= '0;
         sum_ta_ff    <= '0;
         sum_wt_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quantum_ff   <= quantum_in;
         occ_ff       <= occ_in;
         time_ff      <= time_in;
         slice_ff     <= slice_in;
         sum_ta_ff    <= sum_ta_in;
         sum_wt_ff    <= sum_wt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      pid_ff         <= pid_in;
      burst_ff       <= burst_in;
      busy_ff        <= busy_in;
      full_ff        <= full_in;
      done_ff        <= done_in;
      rot_ff         <= rot_in;
      ta_ff          <= ta_in;
      run_ff         <= run_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_ta_ff      <= rsp_ta_in;
      rsp_wt_ff      <= rsp_wt_in;
      rsp_sum_ta_ff  <= rsp_sum_ta_in;
      rsp_sum_wt_ff  <= rsp_sum_wt_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_time_ff    <= rsp_time_in;
   end

   // ------------------------------------------------------------------
   // response channel
   // ------------------------------------------------------------------
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.accepted         = rsp_acc_ff;
   assign rsp_chan.busy_res         = rsp_busy_ff;
   assign rsp_chan.run_id           = rsp_id_ff;
   assign rsp_chan.run_elapsed      = rsp_elapsed_ff;
   assign rsp_chan.done_res         = rsp_done_ff;
   assign rsp_chan.turnaround       = rsp_ta_ff;
   assign rsp_chan.waiting          = rsp_wt_ff;
   assign rsp_chan.total_turnaround = rsp_sum_ta_ff;
   assign rsp_chan.total_waiting    = rsp_sum_wt_ff;
   assign rsp_chan.done_count       = rsp_count_ff;
   assign rsp_chan.time_now         = rsp_time_ff;

endmodule

`default_nettype wire
